// ----- rtl/hlfr_pkg.sv -----
// ----------------------------------------------------------------------------
// hlfr_pkg: shared types and constants for the header/length frame receiver
// Holds the transfer payload structs, the item and register codes, and the
// register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package hlfr_pkg;

  // Default size of the external frame buffer in bytes.
  localparam int unsigned BufferDepthDefault = 512;

  // Field and state widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned FillW   = 11;
  localparam int unsigned TotalW  = 9;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Register reset values.
  localparam logic [ByteW-1:0]  HeaderReset   = 8'd0;
  localparam logic [ByteW-1:0]  MinLenReset   = 8'd1;
  localparam logic [ByteW-1:0]  MaxLenReset   = 8'd255;
  localparam logic [ByteW-1:0]  OverheadReset = 8'd6;
  localparam logic [TicksW-1:0] TimeoutReset  = 16'd100;

  // Kind of input item.
  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_TICK     = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_LINE_ERR = 2'd3
  } hlfr_op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER   = 3'd0,
    CFG_MIN_LEN  = 3'd1,
    CFG_MAX_LEN  = 3'd2,
    CFG_OVERHEAD = 3'd3,
    CFG_TIMEOUT  = 3'd4
  } hlfr_cfg_e;

  typedef struct packed {
    hlfr_op_e         op;
    logic [ByteW-1:0] data_byte;
  } hlfr_in_t;

  typedef struct packed {
    logic              byte_valid;
    logic [ByteW-1:0]  byte_value;
    logic [IndexW-1:0] byte_index;
    logic              frame_done;
    logic [FillW-1:0]  frame_length;
    logic              nack;
  } hlfr_out_t;

endpackage

`default_nettype wire

// ----- rtl/header_length_frame_receiver.sv -----
// A result is registered and is valid in the cycle after its input transfer.
// Throughput: one item per cycle; the framing state updates in a single pass.
// The input stalls only while a finished result waits and the output stalls.
// Reset (rst_ni low, asynchronous) returns to the header search with no frame
// held and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// header_length_frame_receiver: header/length command framer with timeout
// Frames a received byte stream by header byte and length byte, reports each
// stored byte with its position, holds a completed frame until released, and
// raises a NACK on bad length, overflow, line error or inter-byte timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_frame_receiver #(
  parameter int unsigned BufferDepth = hlfr_pkg::BufferDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hlfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hlfr_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hlfr_pkg::hlfr_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hlfr_pkg::hlfr_out_t           out_data_o
);
  import hlfr_pkg::*;

  logic      in_accept;
  hlfr_out_t result;

  // Framing state and decision logic.
  hlfr_core #(
    .BufferDepth (BufferDepth)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .result_o    (result)
  );

  // Result register between the two sides.
  hlfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_accept_o (in_accept),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/hlfr_core.sv -----
// ----------------------------------------------------------------------------
// hlfr_core: framing state and per-item decision logic
// Holds the configuration registers and the framing state, and computes the
// result of each input item in one pass of compare-and-count logic.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfr_core #(
  parameter int unsigned BufferDepth = hlfr_pkg::BufferDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hlfr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [hlfr_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              in_accept_i,
  input  hlfr_pkg::hlfr_in_t                in_data_i,
  output hlfr_pkg::hlfr_out_t               result_o
);
  import hlfr_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  logic [ByteW-1:0]  header_q, min_len_q, max_len_q, overhead_q;
  logic [TicksW-1:0] timeout_q;

  phase_e            phase_q, phase_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [TicksW-1:0] idle_q, idle_d;
  logic              held_q, held_d;

  logic [FillW-1:0]  fill_next;
  logic [TicksW-1:0] idle_inc;
  logic              restart;
  hlfr_out_t         res;

  // Configuration registers; the user must write only while idle (unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= HeaderReset;
      min_len_q  <= MinLenReset;
      max_len_q  <= MaxLenReset;
      overhead_q <= OverheadReset;
      timeout_q  <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER:   header_q   <= cfg_data_i[ByteW-1:0];
        CFG_MIN_LEN:  min_len_q  <= cfg_data_i[ByteW-1:0];
        CFG_MAX_LEN:  max_len_q  <= cfg_data_i[ByteW-1:0];
        CFG_OVERHEAD: overhead_q <= cfg_data_i[ByteW-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign fill_next = fill_q + FillW'(1);
  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + TicksW'(1);

  // Decide the result of one item and the next framing state.
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    total_d = total_q;
    idle_d  = idle_q;
    held_d  = held_q;
    restart = 1'b0;
    res     = '0;

    case (in_data_i.op)
      OP_BYTE: begin
        if (!held_q) begin
          idle_d = '0;
          case (phase_q)
            PH_HEADER: begin
              if (in_data_i.data_byte == header_q) begin
                res.byte_valid = 1'b1;
                res.byte_value = in_data_i.data_byte;
                res.byte_index = '0;
                fill_d         = FillW'(1);
                phase_d        = PH_LENGTH;
              end
            end
            PH_LENGTH: begin
              if (in_data_i.data_byte < min_len_q || in_data_i.data_byte > max_len_q) begin
                res.nack = 1'b1;
                restart  = 1'b1;
              end else begin
                res.byte_valid = 1'b1;
                res.byte_value = in_data_i.data_byte;
                res.byte_index = IndexW'(1);
                fill_d         = FillW'(2);
                total_d        = {1'b0, in_data_i.data_byte} + {1'b0, overhead_q};
                phase_d        = PH_COLLECT;
              end
            end
            PH_COLLECT: begin
              if (fill_q >= FillW'(BufferDepth)) begin
                res.nack = 1'b1;
                restart  = 1'b1;
              end else if (fill_next > FillW'(total_q)) begin
                // The frame is already complete or the total was too short.
                res.nack = 1'b1;
                restart  = 1'b1;
              end else begin
                res.byte_valid = 1'b1;
                res.byte_value = in_data_i.data_byte;
                res.byte_index = fill_q[IndexW-1:0];
                fill_d         = fill_next;
                if (fill_next == FillW'(total_q)) begin
                  res.frame_done   = 1'b1;
                  res.frame_length = fill_next;
                  held_d           = 1'b1;
                end
              end
            end
            default: begin
              res.nack = 1'b1;
              restart  = 1'b1;
            end
          endcase
        end
      end
      OP_TICK: begin
        if (!held_q && phase_q != PH_HEADER) begin
          idle_d = idle_inc;
          if (idle_inc > timeout_q) begin
            res.nack = 1'b1;
            restart  = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (held_q) begin
          held_d  = 1'b0;
          restart = 1'b1;
        end
      end
      OP_LINE_ERR: begin
        if (!held_q) begin
          res.nack = 1'b1;
          restart  = 1'b1;
        end
      end
      default: ;
    endcase

    // Return to the header search.
    if (restart) begin
      phase_d = PH_HEADER;
      fill_d  = '0;
      total_d = '0;
      idle_d  = '0;
    end
  end

  assign result_o = res;

  // Framing state advances once per accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      fill_q  <= '0;
      total_q <= '0;
      idle_q  <= '0;
      held_q  <= 1'b0;
    end else if (in_accept_i) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      idle_q  <= idle_d;
      held_q  <= held_d;
    end
  end

`ifndef SYNTHESIS
  // A rejected byte is never also taken into the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i |-> !(res.byte_valid && res.nack))
    else $error("hlfr_core: byte accepted and rejected at once");

  // Completing a frame leaves it held for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i && res.frame_done |=> held_q)
    else $error("hlfr_core: completed frame not held");

  // While a frame is held, everything but a release gives an empty result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i && held_q && in_data_i.op != OP_RELEASE |-> res == '0)
    else $error("hlfr_core: activity while a frame is held");

  // The header search never carries a fill count or an idle count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> fill_q == '0 && idle_q == '0)
    else $error("hlfr_core: stale count during header search");
`endif

endmodule

`default_nettype wire

// ----- rtl/hlfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// hlfr_out_reg: result register of the frame receiver
// Holds one result until the downstream side takes it, and stalls the input
// side only while a held result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfr_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 in_accept_o,
  input  hlfr_pkg::hlfr_out_t  result_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hlfr_pkg::hlfr_out_t  out_data_o
);
  import hlfr_pkg::*;

  logic      valid_q;
  hlfr_out_t data_q;

  // The register can load whenever it is empty or being drained this cycle.
  assign in_stall_o  = valid_q && out_stall_i;
  assign in_accept_o = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_accept_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept_o) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- dv/header_length_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_length_frame_receiver_tb: self-checking bench for the frame receiver
// Drives directed and random byte, tick, release and line-error items through
// the input channel, predicts every result with a behavioral copy of the
// framing logic, and compares each output transfer against it in order.
// ----------------------------------------------------------------------------

module header_length_frame_receiver_tb;

  import hlfr_pkg::*;

  localparam int unsigned BufferDepth = BufferDepthDefault;
  localparam int          CycleLimit  = 600000;

  // Framing phase of the behavioral copy.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_COLLECT = 2'd2,
    PH_SPARE   = 2'd3
  } rx_phase_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgW-1:0]     cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  hlfr_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hlfr_out_t           out_data_o;

  // Register mirrors.
  logic [ByteW-1:0]    cfg_header;
  logic [ByteW-1:0]    cfg_min_len;
  logic [ByteW-1:0]    cfg_max_len;
  logic [ByteW-1:0]    cfg_overhead;
  logic [TicksW-1:0]   cfg_timeout;

  // Framing state of the behavioral copy.
  rx_phase_e           rx_phase;
  logic [FillW-1:0]    rx_fill;
  logic [FillW-1:0]    rx_total;
  logic [TicksW-1:0]   rx_idle;
  logic                rx_held;

  hlfr_out_t           expected_results[$];
  hlfr_out_t           want_result;
  int                  mismatch_count  = 0;
  int                  effective_items = 0;
  int                  cycle_count     = 0;
  int                  send_idle_pct   = 20;
  int                  recv_idle_pct   = 78;

  header_length_frame_receiver #(
    .BufferDepth(BufferDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run guard: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("header_length_frame_receiver verification failed");
    $finish;
  end

  // Return the framing state to the header search.
  function automatic void restart_search_state();
    rx_phase = PH_HEADER;
    rx_fill  = '0;
    rx_total = '0;
    rx_idle  = '0;
  endfunction

  // Work out the result of one accepted item and advance the framing state.
  function automatic hlfr_out_t predict_frame_result(hlfr_in_t item);
    hlfr_out_t        res;
    logic [FillW-1:0] next_fill;
    logic [ByteW-1:0] b;
    res       = '0;
    b         = item.data_byte;
    next_fill = rx_fill + FillW'(1);
    case (item.op)
      OP_BYTE: begin
        if (!rx_held) begin
          rx_idle = '0;
          case (rx_phase)
            PH_HEADER: begin
              if (b == cfg_header) begin
                effective_items++;
                res.byte_valid = 1'b1;
                res.byte_value = b;
                rx_fill        = 11'd1;
                rx_phase       = PH_LENGTH;
              end
            end
            PH_LENGTH: begin
              effective_items++;
              if (b < cfg_min_len || b > cfg_max_len) begin
                res.nack = 1'b1;
                restart_search_state();
              end else begin
                res.byte_valid = 1'b1;
                res.byte_value = b;
                res.byte_index = 10'd1;
                rx_fill        = 11'd2;
                rx_total       = {3'b000, b} + {3'b000, cfg_overhead};
                rx_phase       = PH_COLLECT;
              end
            end
            PH_COLLECT: begin
              effective_items++;
              if (rx_fill >= BufferDepth || next_fill > rx_total) begin
                res.nack = 1'b1;
                restart_search_state();
              end else begin
                res.byte_valid = 1'b1;
                res.byte_value = b;
                res.byte_index = rx_fill[IndexW-1:0];
                rx_fill        = next_fill;
                if (next_fill == rx_total) begin
                  res.frame_done   = 1'b1;
                  res.frame_length = next_fill;
                  rx_held          = 1'b1;
                end
              end
            end
            default: begin
              effective_items++;
              res.nack = 1'b1;
              restart_search_state();
            end
          endcase
        end
      end
      OP_TICK: begin
        // Ticks only count while a frame is under way.
        if (!rx_held && rx_phase != PH_HEADER) begin
          effective_items++;
          if (rx_idle != '1) rx_idle = rx_idle + TicksW'(1);
          if (rx_idle > cfg_timeout) begin
            res.nack = 1'b1;
            restart_search_state();
          end
        end
      end
      OP_RELEASE: begin
        if (rx_held) begin
          effective_items++;
          rx_held = 1'b0;
          restart_search_state();
        end
      end
      default: begin
        if (!rx_held) begin
          effective_items++;
          res.nack = 1'b1;
          restart_search_state();
        end
      end
    endcase
    return res;
  endfunction

  // Offer one item, idling at random first, and record its expected result.
  task automatic send_item(input hlfr_op_e op, input logic [ByteW-1:0] value);
    hlfr_in_t item;
    item.op        = op;
    item.data_byte = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    expected_results.push_back(predict_frame_result(item));
  endtask

  // Hold the input idle until every expected result has been checked.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable afterwards.
  task automatic write_reg(input hlfr_cfg_e idx, input logic [CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_HEADER:   cfg_header   = value[ByteW-1:0];
      CFG_MIN_LEN:  cfg_min_len  = value[ByteW-1:0];
      CFG_MAX_LEN:  cfg_max_len  = value[ByteW-1:0];
      CFG_OVERHEAD: cfg_overhead = value[ByteW-1:0];
      CFG_TIMEOUT:  cfg_timeout  = value;
      default: ;
    endcase
  endtask

  // Drain the block, then load all five registers.
  task automatic apply_settings(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] lo,
                                input logic [ByteW-1:0] hi, input logic [ByteW-1:0] ovh,
                                input logic [TicksW-1:0] tmo);
    wait_until_drained();
    write_reg(CFG_HEADER,   {8'h00, hdr});
    write_reg(CFG_MIN_LEN,  {8'h00, lo});
    write_reg(CFG_MAX_LEN,  {8'h00, hi});
    write_reg(CFG_OVERHEAD, {8'h00, ovh});
    write_reg(CFG_TIMEOUT,  tmo);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly legal lengths near the minimum, sometimes just outside the limits.
  function automatic logic [ByteW-1:0] pick_length();
    int lo;
    int hi;
    int r;
    lo = cfg_min_len;
    hi = cfg_max_len;
    r  = $urandom_range(0, 99);
    if (r < 6 || lo > hi) return 8'($urandom_range(0, 255));
    if (r < 16 && lo > 0) return 8'(lo - 1);
    if (r < 26 && hi < 255) return 8'(hi + 1);
    return 8'(lo + $urandom_range(0, (hi - lo > 6) ? 6 : hi - lo));
  endfunction

  // Frame content, with the header value showing up now and then.
  function automatic logic [ByteW-1:0] payload_byte();
    if ($urandom_range(0, 4) == 0) return cfg_header;
    return 8'($urandom_range(0, 255));
  endfunction

  // Occasional tick runs, a few of them long enough to time the frame out.
  task automatic maybe_tick_burst();
    int n;
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 3) == 0) n = (cfg_timeout > 40) ? 40 : int'(cfg_timeout) + 1;
      else n = $urandom_range(0, (cfg_timeout < 3) ? int'(cfg_timeout) : 3);
      repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // A few items of any kind.
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item(hlfr_op_e'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
  endtask

  // Header, length and body, with line errors and timeouts mixed in, then release.
  task automatic send_frame_attempt();
    int       guard;
    int       k;
    hlfr_op_e quiet_op;
    send_item(OP_BYTE, cfg_header);
    maybe_tick_burst();
    if (rx_phase == PH_LENGTH) send_item(OP_BYTE, pick_length());
    guard = 0;
    while (rx_phase == PH_COLLECT && !rx_held && guard < 600) begin
      maybe_tick_burst();
      if ($urandom_range(0, 99) < 2) send_item(OP_LINE_ERR, 8'($urandom_range(0, 255)));
      else send_item(OP_BYTE, payload_byte());
      guard++;
    end
    if (rx_held) begin
      // A held frame ignores everything but a release.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          k        = $urandom_range(0, 2);
          quiet_op = (k == 2) ? OP_LINE_ERR : ((k == 1) ? OP_TICK : OP_BYTE);
          send_item(quiet_op, 8'($urandom_range(0, 255)));
        end
      end
      send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Random register settings, extremes included.
  task automatic pick_random_settings();
    int kind;
    int lo;
    int hi;
    int ovh;
    int tmo;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        // Totals of two or less: every body byte overruns.
        lo  = 0;
        hi  = $urandom_range(0, 2);
        ovh = $urandom_range(0, 2 - hi);
        tmo = $urandom_range(0, 2);
      end
      1: begin
        lo  = 255;
        hi  = 255;
        ovh = 0;
        tmo = 65535;
      end
      2: begin
        // Minimum above maximum: every length is refused.
        lo  = $urandom_range(1, 255);
        hi  = $urandom_range(0, lo - 1);
        ovh = $urandom_range(0, 255);
        tmo = $urandom_range(0, 65535);
      end
      default: begin
        lo  = $urandom_range(0, 10);
        hi  = ($urandom_range(0, 4) == 0) ? 255 : lo + $urandom_range(0, 10);
        ovh = $urandom_range(0, 8);
        tmo = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 12);
      end
    endcase
    apply_settings(8'($urandom_range(0, 255)), 8'(lo), 8'(hi), 8'(ovh), 16'(tmo));
  endtask

  // Reset defaults: idle line error, idle tick, empty release, header search.
  task automatic test_idle_search();
    send_item(OP_LINE_ERR, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_RELEASE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
  endtask

  // Zero total overruns on the first body byte; zero timeout fires on one tick.
  task automatic test_short_total();
    apply_settings(8'hFF, 8'd0, 8'd255, 8'd0, 16'd0);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h00);
  endtask

  // Length above the limit, a held frame that ignores traffic, and a timeout.
  task automatic test_held_frame();
    apply_settings(8'h3C, 8'd3, 8'd3, 8'd0, 16'd2);
    send_item(OP_BYTE, 8'h3C);
    send_item(OP_BYTE, 8'd4);
    send_item(OP_BYTE, 8'h3C);
    send_item(OP_BYTE, 8'd3);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'hC3);
    send_item(OP_BYTE, 8'h3C);
    send_item(OP_LINE_ERR, 8'h00);
    send_item(OP_RELEASE, 8'h00);
    send_item(OP_RELEASE, 8'h00);
    send_item(OP_BYTE, 8'h3C);
    repeat (3) send_item(OP_TICK, 8'h00);
  endtask

  // Largest length with the largest overhead.
  task automatic test_longest_frame();
    apply_settings(8'h5A, 8'd0, 8'd255, 8'd255, 16'hFFFF);
    send_item(OP_BYTE, 8'h5A);
    send_item(OP_BYTE, 8'd255);
    while (rx_phase == PH_COLLECT && !rx_held) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    send_item(OP_RELEASE, 8'h00);
  endtask

  // Random frames under changing settings with the given idle rates.
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
    int start_count;
    int setting_count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count   = effective_items;
    while (effective_items - start_count < target) begin
      pick_random_settings();
      setting_count = effective_items;
      while (effective_items - setting_count < 150 &&
             effective_items - start_count < target) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_frame_attempt();
      end
    end
  endtask

  // Output side: random stall, and each result transfer checked in order.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result transfer: v=%0b val=%02h idx=%0d done=%0b len=%0d nack=%0b",
                   out_data_o.byte_valid, out_data_o.byte_value, out_data_o.byte_index,
                   out_data_o.frame_done, out_data_o.frame_length, out_data_o.nack);
        mismatch_count++;
      end else begin
        want_result = expected_results.pop_front();
        if (out_data_o.byte_valid !== want_result.byte_valid ||
            out_data_o.byte_value !== want_result.byte_value ||
            out_data_o.byte_index !== want_result.byte_index ||
            out_data_o.frame_done !== want_result.frame_done ||
            out_data_o.frame_length !== want_result.frame_length ||
            out_data_o.nack !== want_result.nack) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected v=%0b val=%02h idx=%0d done=%0b len=%0d nack=%0b",
                     want_result.byte_valid, want_result.byte_value, want_result.byte_index,
                     want_result.frame_done, want_result.frame_length, want_result.nack);
            $display("          actual   v=%0b val=%02h idx=%0d done=%0b len=%0d nack=%0b",
                     out_data_o.byte_valid, out_data_o.byte_value, out_data_o.byte_index,
                     out_data_o.frame_done, out_data_o.frame_length, out_data_o.nack);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    cfg_header   = HeaderReset;
    cfg_min_len  = MinLenReset;
    cfg_max_len  = MaxLenReset;
    cfg_overhead = OverheadReset;
    cfg_timeout  = TimeoutReset;
    rx_held      = 1'b0;
    restart_search_state();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_search();
    test_short_total();
    test_held_frame();
    test_longest_frame();
    test_random_traffic(20, 78, 450);
    test_random_traffic(78, 20, 450);
    test_random_traffic(0, 0, 460);

    wait_until_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("header_length_frame_receiver verification clean");
    end else begin
      $display("header_length_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hlfr_pkg.sv
rtl/hlfr_core.sv
rtl/hlfr_out_reg.sv
rtl/header_length_frame_receiver.sv
dv/header_length_frame_receiver_tb.sv
